/* design/assert_macros.svh */
// concurrent assertion helpers, sampled on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/fct_pkg.sv */
package fct_pkg;

   localparam logic [7:0] CHAR_HEADER  = 8'h3E;   // '>'
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] LETTER_LOW   = 8'd65;
   localparam logic [7:0] LETTER_HIGH  = 8'd122;
   localparam logic [7:0] CHAR_STOP    = 8'h2D;   // '-'
   localparam logic [7:0] CHAR_UNKNOWN = 8'h2A;   // '*'

   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_U_UP = 8'h55;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_T_LO = 8'h74;
   localparam logic [7:0] CHAR_U_LO = 8'h75;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // codon index {b0,b1,b2} in 2-bit codes; first character sits at entry 63
   localparam logic [63:0][7:0] AMINO_TABLE =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV-Y-YSSSS-CWCLFLF";

   typedef struct packed {
      logic       known;
      logic [1:0] code;
   } base_code_type;

   function automatic base_code_type base_code(input logic [7:0] b);
      base_code_type r;
      r.known = 1'b1;
      r.code  = BASE_A;
      case (b)
         CHAR_A_UP: r.code = BASE_A;
         CHAR_C_UP: r.code = BASE_C;
         CHAR_G_UP: r.code = BASE_G;
         CHAR_T_UP: r.code = BASE_T;
         default:   r.known = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] normalize(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CHAR_U_UP, CHAR_U_LO, CHAR_T_LO: r = CHAR_T_UP;
         CHAR_A_LO: r = CHAR_A_UP;
         CHAR_C_LO: r = CHAR_C_UP;
         CHAR_G_LO: r = CHAR_G_UP;
         default:   r = b;
      endcase
      return r;
   endfunction

endpackage

/* design/fct_codon_lut.sv */
module fct_codon_lut import fct_pkg::*; (
   input  logic [7:0] base0,
   input  logic [7:0] base1,
   input  logic [7:0] base2,
   output logic [7:0] amino
);

   base_code_type c0, c1, c2;
   logic [5:0]    idx;

   always_comb begin
      c0  = base_code(base0);
      c1  = base_code(base1);
      c2  = base_code(base2);
      idx = {c0.code, c1.code, c2.code};
      if (c0.known && c1.known && c2.known) begin
         amino = AMINO_TABLE[~idx];
      end else begin
         amino = CHAR_UNKNOWN;
      end
   end

endmodule

/* design/fasta_codon_translator.sv */
// path: accepted bytes enter the input register, completed codons load the output register
// throughput: one request per cycle; a stalled result blocks only when a codon completes
// rate is set by the combinational parse/translate step between the two registers
// reset: synchronous, active high; frame returns to 1, header mode on, counters cleared
// held codon bases are not reset and are always written before they are read
`include "assert_macros.svh"

module fasta_codon_translator import fct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] text_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] amino_letter
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data      // reading_frame
);

   logic [1:0] frame_ff;
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       hdr_ff, hdr_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] seen_ff, seen_in;
   logic [7:0] held0_ff, held1_ff;
   logic       out_valid_ff;
   logic [7:0] out_data_ff;

   logic       is_hdr, is_nl, is_letter, skip, is_result, keep;
   logic       advance;
   logic [7:0] norm_byte;
   logic [7:0] amino;
   logic       rec_clear;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // decode of the byte in the input register, independent of flow control
   always_comb begin
      is_hdr    = (s1_byte_ff == CHAR_HEADER);
      is_nl     = (s1_byte_ff == CHAR_NEWLINE);
      is_letter = !is_hdr && !is_nl && !hdr_ff &&
                  (s1_byte_ff >= LETTER_LOW) && (s1_byte_ff <= LETTER_HIGH);
      skip      = ({1'b0, seen_ff} + 3'd1) < {1'b0, frame_ff};
      keep      = is_letter && !skip;
      is_result = keep && (pos_ff == 2'd2);
      norm_byte = normalize(s1_byte_ff);
   end

   assign advance    = s1_valid_ff && (!is_result || !out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   fct_codon_lut u_lut (
      .base0 (held0_ff),
      .base1 (held1_ff),
      .base2 (norm_byte),
      .amino (amino)
   );

   // record state update
   always_comb begin
      hdr_in  = hdr_ff;
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (advance) begin
         if (is_hdr) begin
            hdr_in  = 1'b1;
            pos_in  = 2'd0;
            seen_in = 2'd0;
         end else if (is_nl) begin
            hdr_in = 1'b0;
         end else if (is_letter) begin
            if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
            if (keep) begin
               pos_in = (pos_ff == 2'd2) ? 2'd0 : pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= 2'd1;
         s1_valid_ff  <= 1'b0;
         hdr_ff       <= 1'b1;
         pos_ff       <= 2'd0;
         seen_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            frame_ff <= csr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         hdr_ff  <= hdr_in;
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         if (advance && is_result) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
      end
      if (advance && keep && (pos_ff == 2'd0)) begin
         held0_ff <= norm_byte;
      end
      if (advance && keep && (pos_ff == 2'd1)) begin
         held1_ff <= norm_byte;
      end
      if (advance && is_result) begin
         out_data_ff <= amino;
      end
   end

   assign rec_clear = (pos_ff == 2'd0) && (seen_ff == 2'd0) && hdr_ff;

   `ASSERT_NOW(a_stall_has_item, clock, reset, !req_tready, s1_valid_ff, "stall with no request")
   `ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff != 2'd3, "codon position out of range")
   `ASSERT_NEXT(a_hdr_clears, clock, reset, advance && is_hdr, rec_clear, "header kept record state")
   `ASSERT_NEXT(a_result_loaded, clock, reset, advance && is_result, rsp_tvalid, "codon gave no result")

endmodule

/* test/fasta_codon_translator_test.sv */
module fasta_codon_translator_test;
   import fct_pkg::*;

   localparam int STUCK_LIMIT = 400;
   localparam int SETTLE_CYCLES = 4;

   // first character belongs to codon AAA, the last to TTT
   localparam logic [8*64-1:0] CODON_AMINO =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV-Y-YSSSS-CWCLFLF";
   localparam logic [8*10-1:0] NUCLEOTIDES = "ACGTacgtuU";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] text_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] amino_letter
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = '0;

   // translator state as seen from the stream
   logic [1:0] frame_setting;
   logic       in_header_line;
   logic [1:0] codon_fill;
   logic [1:0] skip_count;
   logic [7:0] held_letters [2];

   logic [7:0] pending_aminos [$];
   int         errors = 0;
   bit         req_idle_on = 1'b1;
   bit         rsp_idle_on = 1'b1;
   int         rsp_hold = 0;

   always #1 clock = ~clock;

   fasta_codon_translator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic int base_index(input logic [7:0] letter);
      case (letter)
         CHAR_A_UP: return 0;
         CHAR_C_UP: return 1;
         CHAR_G_UP: return 2;
         CHAR_T_UP: return 3;
         default:   return -1;
      endcase
   endfunction

   function automatic logic [7:0] fold_base(input logic [7:0] raw);
      case (raw)
         CHAR_U_UP, CHAR_U_LO, CHAR_T_LO: return CHAR_T_UP;
         CHAR_A_LO: return CHAR_A_UP;
         CHAR_C_LO: return CHAR_C_UP;
         CHAR_G_LO: return CHAR_G_UP;
         default:   return raw;
      endcase
   endfunction

   function automatic logic [7:0] codon_to_amino(input logic [7:0] b0, b1, b2);
      int c0, c1, c2;
      c0 = base_index(b0);
      c1 = base_index(b1);
      c2 = base_index(b2);
      if (c0 < 0 || c1 < 0 || c2 < 0)
         return CHAR_UNKNOWN;
      return CODON_AMINO[8 * (63 - (c0 * 16 + c1 * 4 + c2)) +: 8];
   endfunction

   // advance the stream state by one accepted byte, queue any amino letter
   task automatic track_byte(input logic [7:0] raw);
      logic [7:0] letter;
      if (raw == CHAR_HEADER) begin
         in_header_line = 1'b1;
         codon_fill = '0;
         skip_count = '0;
      end else if (raw == CHAR_NEWLINE) begin
         in_header_line = 1'b0;
      end else if (!in_header_line && raw >= LETTER_LOW && raw <= LETTER_HIGH) begin
         if (int'(skip_count) + 1 < int'(frame_setting)) begin
            skip_count = skip_count + 2'd1;
         end else begin
            if (skip_count != 2'd3)
               skip_count = skip_count + 2'd1;
            letter = fold_base(raw);
            if (codon_fill < 2'd2) begin
               held_letters[codon_fill[0]] = letter;
               codon_fill = codon_fill + 2'd1;
            end else begin
               codon_fill = '0;
               pending_aminos.push_back(codon_to_amino(held_letters[0], held_letters[1],
                                                       letter));
            end
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] raw);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      track_byte(raw);
   endtask

   // hold the sender until every amino letter is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_aminos.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input logic [1:0] frame);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= frame;
      do @(posedge clock); while (!csr_ready);
      frame_setting = frame;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] sequence_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 94)
         return NUCLEOTIDES[8 * $urandom_range(0, 9) +: 8];
      return 8'($urandom_range(LETTER_LOW, LETTER_HIGH));
   endfunction

   function automatic logic [7:0] header_byte();
      logic [7:0] raw;
      raw = 8'($urandom_range(0, 255));
      return (raw == CHAR_NEWLINE) ? CHAR_HEADER : raw;
   endfunction

   // multi-record text with stray random bytes, cut off wherever the byte budget runs out
   task automatic send_records(input int budget);
      logic [7:0] chunk [$];
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         chunk.delete();
         if ($urandom_range(0, 99) < 85) begin
            chunk.push_back(CHAR_HEADER);
            repeat ($urandom_range(0, 8)) chunk.push_back(header_byte());
            chunk.push_back(CHAR_NEWLINE);
            repeat ($urandom_range(1, 3)) begin
               len = $urandom_range(1, 30);
               repeat (len) chunk.push_back(sequence_byte());
               chunk.push_back(CHAR_NEWLINE);
            end
         end else begin
            chunk.push_back(8'($urandom_range(0, 255)));
         end
         foreach (chunk[i]) begin
            if (sent < budget) begin
               send_byte(chunk[i]);
               sent++;
            end
         end
      end
   endtask

   task automatic test_directed();
      logic [7:0] text [30] = '{
         "Z", CHAR_NEWLINE,
         "A", "T", "G", "U", "A", "G", "u", "G", "a", "t", "c", "[",
         "N", 8'h00, "@", "z", "{", 8'hFF, "g",
         "c", "a", CHAR_HEADER, "q", CHAR_HEADER, CHAR_NEWLINE,
         "G", "G", "C"};
      foreach (text[i]) send_byte(text[i]);
   endtask

   // the phases can end mid-record, so a write may also change the frame inside a record
   task automatic test_frame_sweep();
      logic [1:0] frames [6] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0};
      foreach (frames[i]) begin
         set_frame(frames[i]);
         send_records(60);
      end
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_frame(2'd2);
      send_records(60);
      rsp_idle_on = 1'b1;
      send_records(30);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      send_records(30);
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_noise();
      int pick;
      set_frame(2'd3);
      repeat (100) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send_byte(CHAR_NEWLINE);
         else if (pick < 15)
            send_byte(CHAR_HEADER);
         else if (pick < 45)
            send_byte(sequence_byte());
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // receiver side: stall for a random hold after each result while rsp_idle_on is set
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_aminos.size() == 0) begin
            $error("amino_letter: expected none, got %h", rsp_tdata);
            errors++;
         end else if (rsp_tdata !== pending_aminos[0]) begin
            $error("amino_letter: expected %h, got %h", pending_aminos[0], rsp_tdata);
            errors++;
            void'(pending_aminos.pop_front());
         end else begin
            void'(pending_aminos.pop_front());
         end
         rsp_hold = rsp_idle_on ? $urandom_range(0, 16) : 0;
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("** fasta_codon_translator: FAILED **");
      $finish;
   end

   initial begin
      frame_setting  = 2'd1;
      in_header_line = 1'b1;
      codon_fill     = '0;
      skip_count     = '0;
      held_letters[0] = '0;
      held_letters[1] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_frame_sweep();
      test_back_to_back();
      test_noise();
      drain();

      if (errors == 0)
         $display("** fasta_codon_translator: PASSED **");
      else
         $display("** fasta_codon_translator: FAILED **");
      $finish;
   end

endmodule
